/* hdl/hid_keyboard_report_diff_defines.svh */
// Assertion macros used by the keyboard report differencer back end.
`ifndef HID_KEYBOARD_REPORT_DIFF_DEFINES_SVH
`define HID_KEYBOARD_REPORT_DIFF_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HKRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hkrd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define HKRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hkrd assertion failed");

`endif

/* hdl/hkrd_pkg.sv */
// Shared constants and types of the keyboard report differencer.
package hkrd_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int MOD_BITS = 8;
	localparam int EV_BITS = MOD_BITS + 2 * KEY_SLOTS;
	localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef logic [KEY_SLOTS-1:0][7:0] key_array_t;

	typedef struct packed {
		logic [EV_BITS-1:0] mask;
		logic [MOD_BITS-1:0] mods;
		key_array_t old_keys;
		key_array_t new_keys;
	} event_set_t;

	typedef struct packed {
		logic push;
		event_set_t data;
	} queue_write_t;

endpackage

/* hdl/hkrd_front.sv */
// Front end: accepts reports, computes the change mask and keeps the stored report.
module hkrd_front
	import hkrd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic report_present,
	input logic [MOD_BITS-1:0] mods,
	input key_array_t keys,
	output queue_write_t qwr
);

	logic [MOD_BITS-1:0] prev_mods_q;
	key_array_t stored_keys_q;
	logic [KEY_SLOTS-1:0] release_m;
	logic [KEY_SLOTS-1:0] press_m;
	logic [EV_BITS-1:0] mask;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			release_m[i] = (stored_keys_q[i] != 8'd0);
			press_m[i] = (keys[i] != 8'd0);
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (keys[j] == stored_keys_q[i]) begin
					release_m[i] = 1'b0;
				end
				if (stored_keys_q[j] == keys[i]) begin
					press_m[i] = 1'b0;
				end
			end
		end
		mask = {press_m, release_m, mods ^ prev_mods_q};
	end

	always_comb begin
		qwr.push = accept && report_present && (mask != '0);
		qwr.data.mask = mask;
		qwr.data.mods = mods;
		qwr.data.old_keys = stored_keys_q;
		qwr.data.new_keys = keys;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			stored_keys_q <= '0;
		end else if (accept && report_present) begin
			prev_mods_q <= mods;
			stored_keys_q <= keys;
		end
	end

endmodule

/* hdl/hkrd_queue.sv */
// Short queue of pending event sets between the front and back ends.
module hkrd_queue
	import hkrd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input queue_write_t qwr,
	input logic pop,
	output logic full,
	output logic head_valid,
	output event_set_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	event_set_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = entries_q[rd_ptr_q];
	assign do_push = qwr.push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= qwr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/hkrd_back.sv */
// Back end: walks an event set lowest bit first, one event per unstalled cycle.
`include "hid_keyboard_report_diff_defines.svh"
module hkrd_back
	import hkrd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input event_set_t head,
	output logic pop,
	output logic event_valid,
	input logic event_stall,
	output logic [7:0] usage_code,
	output logic pressed,
	output logic last_event
);

	logic busy_q;
	event_set_t cur_q;
	logic out_valid_q;
	logic [7:0] usage_q;
	logic pressed_q;
	logic last_q;

	logic [EV_BITS-1:0] low_bit;
	logic [EV_BITS-1:0] rest;
	logic [EV_BITS-1:0][7:0] code_of;
	logic [EV_BITS-1:0] down_of;
	logic [7:0] code_sel;
	logic down_sel;
	logic emit;
	logic is_last;

	always_comb begin
		for (int i = 0; i < MOD_BITS; i++) begin
			code_of[i] = MOD_USAGE_BASE + 8'(i);
			down_of[i] = cur_q.mods[i];
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			code_of[MOD_BITS + i] = cur_q.old_keys[i];
			down_of[MOD_BITS + i] = 1'b0;
			code_of[MOD_BITS + KEY_SLOTS + i] = cur_q.new_keys[i];
			down_of[MOD_BITS + KEY_SLOTS + i] = 1'b1;
		end
		low_bit = cur_q.mask & (~cur_q.mask + 1'b1);
		rest = cur_q.mask & ~low_bit;
		code_sel = '0;
		down_sel = 1'b0;
		for (int i = 0; i < EV_BITS; i++) begin
			code_sel = code_sel | ({8{low_bit[i]}} & code_of[i]);
			down_sel = down_sel | (low_bit[i] & down_of[i]);
		end
	end

	assign emit = busy_q && (!out_valid_q || !event_stall);
	assign is_last = (rest == '0);
	assign pop = head_valid && (!busy_q || (emit && is_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end else if (emit) begin
			cur_q.mask <= rest;
		end
		if (emit) begin
			usage_q <= code_sel;
			pressed_q <= down_sel;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && is_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!event_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign event_valid = out_valid_q;
	assign usage_code = usage_q;
	assign pressed = pressed_q;
	assign last_event = last_q;

	`HKRD_ASSERT_SAME(a_busy_has_events, clk, arst_n, busy_q, cur_q.mask != '0)
	`HKRD_ASSERT_SAME(a_pop_needs_entry, clk, arst_n, pop, head_valid)
	`HKRD_ASSERT_NEXT(a_last_frees_back, clk, arst_n, emit && is_last && !pop, !busy_q)
	`HKRD_ASSERT_NEXT(a_emit_fills_output, clk, arst_n, emit, out_valid_q)

endmodule

/* hdl/hid_keyboard_report_diff.sv */
// Top level of the keyboard report differencer.
// A report is taken in any cycle in which the event queue has room, so reports may follow
// each other back to back; one with report_present low only passes. Each present report is
// compared with the stored one combinationally; a change set that is not empty is queued.
// Events then leave at one per cycle while event_stall is low, modifier changes first,
// then releases, then presses, with last_event on the final one; a report causes at most
// 20 events, and the event emitter sets the sustained rate. Reports that cause no event
// take no emitter time.
module hid_keyboard_report_diff
	import hkrd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic report_valid,
	output logic report_stall,
	input logic report_present,
	input logic [7:0] modifier_bits,
	input logic [7:0] key_slot_0,
	input logic [7:0] key_slot_1,
	input logic [7:0] key_slot_2,
	input logic [7:0] key_slot_3,
	input logic [7:0] key_slot_4,
	input logic [7:0] key_slot_5,
	output logic event_valid,
	input logic event_stall,
	output logic [7:0] usage_code,
	output logic pressed,
	output logic last_event
);

	key_array_t keys;
	queue_write_t qwr;
	event_set_t head;
	logic head_valid;
	logic full;
	logic pop;
	logic accept;

	assign keys[0] = key_slot_0;
	assign keys[1] = key_slot_1;
	assign keys[2] = key_slot_2;
	assign keys[3] = key_slot_3;
	assign keys[4] = key_slot_4;
	assign keys[5] = key_slot_5;

	assign report_stall = full;
	assign accept = report_valid && !full;

	hkrd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.report_present(report_present),
		.mods(modifier_bits),
		.keys(keys),
		.qwr(qwr)
	);

	hkrd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.qwr(qwr),
		.pop(pop),
		.full(full),
		.head_valid(head_valid),
		.head(head)
	);

	hkrd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.usage_code(usage_code),
		.pressed(pressed),
		.last_event(last_event)
	);

endmodule

/* bench/hid_keyboard_report_diff_test.sv */
// Self-checking testbench for the keyboard report differencer with a key event predictor.
module hid_keyboard_report_diff_test;
	import hkrd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] usage;
		logic down;
		logic last_one;
	} key_event_t;

	class keyboard_tracker;
		logic [7:0] held_mods;
		key_array_t held_keys;
		key_event_t pending_events[$];
		int failures;

		function new();
			held_mods = '0;
			held_keys = '0;
			failures = 0;
		endfunction

		function bit listed(key_array_t list, logic [7:0] code);
			if (code == 8'h00) return 1'b0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (list[i] == code) return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_report(logic present, logic [7:0] mods, key_array_t keys);
			key_event_t batch [MOD_BITS + 2 * KEY_SLOTS];
			logic [7:0] changed;
			int n;
			if (!present) return;
			n = 0;
			changed = mods ^ held_mods;
			for (int b = 0; b < MOD_BITS; b++) begin
				if (changed[b]) begin
					batch[n] = '{MOD_USAGE_BASE + 8'(b), mods[b], 1'b0};
					n++;
				end
			end
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (held_keys[i] != 8'h00 && !listed(keys, held_keys[i])) begin
					batch[n] = '{held_keys[i], 1'b0, 1'b0};
					n++;
				end
			end
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (keys[i] != 8'h00 && !listed(held_keys, keys[i])) begin
					batch[n] = '{keys[i], 1'b1, 1'b0};
					n++;
				end
			end
			if (n > 0) batch[n - 1].last_one = 1'b1;
			for (int i = 0; i < n; i++) pending_events.push_back(batch[i]);
			held_mods = mods;
			held_keys = keys;
		endfunction

		function void check_event(logic [7:0] usage, logic down, logic last_one);
			key_event_t want;
			if (pending_events.size() == 0) begin
				$error("unexpected event: usage_code %02h pressed %0b last_event %0b",
					usage, down, last_one);
				failures++;
				return;
			end
			want = pending_events.pop_front();
			if (usage !== want.usage) begin
				$error("usage_code expected %02h actual %02h", want.usage, usage);
				failures++;
			end
			if (down !== want.down) begin
				$error("pressed expected %0b actual %0b", want.down, down);
				failures++;
			end
			if (last_one !== want.last_one) begin
				$error("last_event expected %0b actual %0b", want.last_one, last_one);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic report_valid = 1'b0;
	logic report_stall;
	logic report_present = 1'b0;
	logic [7:0] modifier_bits = '0;
	logic [7:0] key_slot_0 = '0;
	logic [7:0] key_slot_1 = '0;
	logic [7:0] key_slot_2 = '0;
	logic [7:0] key_slot_3 = '0;
	logic [7:0] key_slot_4 = '0;
	logic [7:0] key_slot_5 = '0;
	logic event_valid;
	logic event_stall = 1'b0;
	logic [7:0] usage_code;
	logic pressed;
	logic last_event;

	keyboard_tracker tracker;
	bit idling = 1'b1;
	logic [7:0] last_mods = '0;
	key_array_t last_keys = '0;

	hid_keyboard_report_diff dut (
		.clk(clk),
		.arst_n(arst_n),
		.report_valid(report_valid),
		.report_stall(report_stall),
		.report_present(report_present),
		.modifier_bits(modifier_bits),
		.key_slot_0(key_slot_0),
		.key_slot_1(key_slot_1),
		.key_slot_2(key_slot_2),
		.key_slot_3(key_slot_3),
		.key_slot_4(key_slot_4),
		.key_slot_5(key_slot_5),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.usage_code(usage_code),
		.pressed(pressed),
		.last_event(last_event)
	);

	always #5ns clk = ~clk;

	function automatic key_array_t slot_set(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [7:0] d, logic [7:0] e, logic [7:0] f);
		key_array_t r;
		r[0] = a;
		r[1] = b;
		r[2] = c;
		r[3] = d;
		r[4] = e;
		r[5] = f;
		return r;
	endfunction

	// Codes cluster in a small range so that slots overlap and repeat often.
	function automatic logic [7:0] random_code();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) return 8'h00;
		if (pick < 70) return 8'($urandom_range(4, 32));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_report(input logic present, input logic [7:0] mods,
			input key_array_t keys);
		int gap;
		if (idling && $urandom_range(0, 99) < 20) begin
			report_valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		report_valid <= 1'b1;
		report_present <= present;
		modifier_bits <= mods;
		key_slot_0 <= keys[0];
		key_slot_1 <= keys[1];
		key_slot_2 <= keys[2];
		key_slot_3 <= keys[3];
		key_slot_4 <= keys[4];
		key_slot_5 <= keys[5];
		@(posedge clk);
		while (report_stall) @(posedge clk);
		tracker.note_report(present, mods, keys);
		if (present) begin
			last_mods = mods;
			last_keys = keys;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (event_valid && !event_stall) tracker.check_event(usage_code, pressed, last_event);
			event_stall <= idling && ($urandom_range(0, 99) < 20);
		end
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int sent;
		int pick;
		int idx;
		int other;
		logic [7:0] mods;
		logic [7:0] tmp;
		key_array_t keys;
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_report(1'b0, 8'hFF, slot_set(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_report(1'b1, 8'hFF, slot_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(1'b1, 8'h00, slot_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(1'b1, 8'h00, slot_set(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
		send_report(1'b1, 8'h00, slot_set(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
		send_report(1'b1, 8'h00, slot_set(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04));
		send_report(1'b1, 8'h00, slot_set(8'h04, 8'h05, 8'h0A, 8'h0B, 8'h0C, 8'h0D));
		send_report(1'b1, 8'h00, slot_set(8'h1E, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(1'b1, 8'h00, slot_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h00));
		send_report(1'b1, 8'hAA, slot_set(8'h01, 8'h02, 8'h03, 8'h01, 8'h00, 8'h00));
		send_report(1'b0, 8'h55, slot_set(8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66));
		send_report(1'b1, 8'hAA, slot_set(8'h01, 8'h02, 8'h03, 8'h01, 8'h00, 8'h00));
		send_report(1'b1, 8'h55, slot_set(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06));
		send_report(1'b1, 8'hAA, slot_set(8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD));
		send_report(1'b1, 8'h55, slot_set(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_report(1'b1, 8'h00, slot_set(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06));
		send_report(1'b1, 8'hFF, slot_set(8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD));
		send_report(1'b1, 8'h00, slot_set(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_report(1'b1, 8'hE0, slot_set(8'hE0, 8'hE7, 8'h00, 8'h80, 8'h7F, 8'h00));
		send_report(1'b1, 8'h00, slot_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

		sent = 0;
		while (sent < 240) begin
			idling = !(sent >= 100 && sent < 160);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				keys = key_array_t'({$urandom, $urandom});
				send_report(1'b0, 8'($urandom), keys);
			end else begin
				if (pick < 75) begin
					mods = last_mods;
					keys = last_keys;
					repeat ($urandom_range(0, 2)) begin
						idx = $urandom_range(0, MOD_BITS - 1);
						mods[idx] = ~mods[idx];
					end
					repeat ($urandom_range(0, 3)) begin
						idx = $urandom_range(0, KEY_SLOTS - 1);
						keys[idx] = random_code();
					end
					if ($urandom_range(0, 9) == 0) begin
						idx = $urandom_range(0, KEY_SLOTS - 1);
						other = $urandom_range(0, KEY_SLOTS - 1);
						tmp = keys[idx];
						keys[idx] = keys[other];
						keys[other] = tmp;
					end
				end else begin
					mods = 8'($urandom);
					for (int i = 0; i < KEY_SLOTS; i++) keys[i] = random_code();
				end
				send_report(1'b1, mods, keys);
			end
			sent++;
		end
		report_valid <= 1'b0;

		while (tracker.pending_events.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (tracker.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/hkrd_pkg.sv
hdl/hkrd_front.sv
hdl/hkrd_queue.sv
hdl/hkrd_back.sv
hdl/hid_keyboard_report_diff.sv
bench/hid_keyboard_report_diff_test.sv
